@@ rtl/obm_pkg.sv @@
// Package: order book matcher types, constants and controller interface.
`timescale 1ns / 1ps
`default_nettype none
package obm_pkg;
  localparam int BookSlots = 32;
  localparam int SlotW = $clog2(BookSlots);
  localparam int CntW = $clog2(BookSlots + 1);

  localparam logic [1:0] CMD_LIMIT = 2'd0;
  localparam logic [1:0] CMD_MARKET = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;
  localparam logic [1:0] CMD_BAD = 2'd3;

  localparam logic [2:0] K_FILL = 3'd0;
  localparam logic [2:0] K_RESTED = 3'd1;
  localparam logic [2:0] K_DONE = 3'd2;
  localparam logic [2:0] K_CANCELLED = 3'd3;
  localparam logic [2:0] K_MISS = 3'd4;
  localparam logic [2:0] K_FULL = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic fill;
    logic rest;
    logic cancel_free;
    logic emit_fill;
    logic emit_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       scan_done;
    logic       is_cancel;
    logic       is_bad;
    logic       can_fill;
    logic       out_busy;
  } dp_stat_t;
endpackage
`default_nettype wire

@@ rtl/obm_ctrl.sv @@
// Controller: sequences scan, fill, rest and status emission per command.
`timescale 1ns / 1ps
`default_nettype none
module obm_ctrl
  import obm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (stat.scan_done) state_next = ST_DECIDE;
      ST_DECIDE: if (!stat.out_busy) begin
        if (stat.is_cancel || stat.is_bad || !stat.can_fill) state_next = ST_WAIT;
        else state_next = ST_SCAN;
      end
      ST_WAIT: if (!stat.out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        cmd.scan_start = in_valid;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DECIDE: if (!stat.out_busy) begin
        if (stat.is_bad) cmd.emit_status = 1'b1;
        else if (stat.is_cancel) begin
          cmd.cancel_free = 1'b1;
          cmd.emit_status = 1'b1;
        end else if (stat.can_fill) begin
          cmd.fill = 1'b1;
          cmd.emit_fill = 1'b1;
          cmd.scan_start = 1'b1;
        end else begin
          cmd.rest = 1'b1;
          cmd.emit_status = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accepting while busy");
  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_fill && cmd.emit_status)) else $error("double emit");
  a_fill_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |=> state == ST_SCAN) else $error("fill not rescanned");
`endif
endmodule
`default_nettype wire

@@ rtl/obm_datapath.sv @@
// Datapath: slot store, serial best-maker / cancel scan, output register.
`timescale 1ns / 1ps
`default_nettype none
module obm_datapath
  import obm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  in_cmd,
  input  wire logic        in_side,
  input  wire logic [31:0] in_price,
  input  wire logic [31:0] in_quantity,
  input  wire logic [31:0] in_cancel_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [31:0]      maker_id,
  output logic [31:0]      taker_ref,
  output logic [31:0]      fill_price,
  output logic [31:0]      amount,
  output logic             last
);
  logic [BookSlots-1:0] used;
  logic                 s_side [BookSlots];
  logic [31:0]          s_price [BookSlots];
  logic [31:0]          s_amt [BookSlots];
  logic [31:0]          s_id [BookSlots];

  logic [1:0]  c_cmd;
  logic        c_side;
  logic [31:0] c_price, c_qty, c_cid, c_id, next_id;
  logic [CntW-1:0] nfill;
  logic [CntW-1:0] idx;
  logic        best_ok;
  logic [SlotW-1:0] best;
  logic [31:0] b_price, b_amt, b_id;
  logic        free_ok;
  logic [SlotW-1:0] free_idx;

  logic [SlotW-1:0] i;
  logic better, hit, price_ok;
  logic [31:0] f;
  assign i = idx[SlotW-1:0];

  always_comb begin
    hit = 1'b0;
    better = 1'b0;
    if (c_cmd == CMD_CANCEL) hit = used[i] && (s_id[i] == c_cid);
    else if (used[i] && s_side[i] != c_side) begin
      if (!best_ok) better = 1'b1;
      else if (s_price[i] == b_price) better = s_id[i] < b_id;
      else if (c_side == 1'b0) better = s_price[i] < b_price;
      else better = s_price[i] > b_price;
    end
  end

  assign price_ok = (c_cmd == CMD_MARKET) ||
                    (c_side == 1'b0 ? b_price <= c_price : b_price >= c_price);
  assign f = (c_qty < b_amt) ? c_qty : b_amt;

  always_comb begin
    stat.scan_done = (idx == CntW'(BookSlots - 1)) || (c_cmd == CMD_CANCEL && hit);
    stat.is_cancel = (c_cmd == CMD_CANCEL);
    stat.is_bad = (c_cmd == CMD_BAD);
    stat.can_fill = best_ok && price_ok && (c_qty != 32'd0) &&
                    (nfill != CntW'(BookSlots));
    stat.out_busy = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      next_id <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit_fill || cmd.emit_status) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.load) begin
        c_cmd <= in_cmd; c_side <= in_side; c_price <= in_price;
        c_qty <= in_quantity; c_cid <= in_cancel_id; c_id <= next_id;
        nfill <= '0;
        if (in_cmd == CMD_LIMIT || in_cmd == CMD_MARKET) next_id <= next_id + 32'd1;
      end
      if (cmd.scan_start) begin
        idx <= '0; best_ok <= 1'b0; free_ok <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (!stat.scan_done) idx <= idx + CntW'(1);
        if (hit || better) begin
          best_ok <= 1'b1; best <= i;
          b_price <= s_price[i]; b_amt <= s_amt[i]; b_id <= s_id[i];
        end
        if (!used[i] && !free_ok) begin
          free_ok <= 1'b1; free_idx <= i;
        end
      end
      if (cmd.fill) begin
        c_qty <= c_qty - f;
        nfill <= nfill + CntW'(1);
        s_amt[best] <= b_amt - f;
        if (b_amt == f) used[best] <= 1'b0;
      end
      if (cmd.emit_fill) begin
        kind <= K_FILL; maker_id <= b_id; taker_ref <= c_id;
        fill_price <= b_price; amount <= f; last <= 1'b0;
      end
      if (cmd.cancel_free && best_ok) used[best] <= 1'b0;
      if (cmd.rest && c_cmd == CMD_LIMIT && c_qty != 32'd0 && free_ok) begin
        used[free_idx] <= 1'b1;
        s_side[free_idx] <= c_side; s_price[free_idx] <= c_price;
        s_amt[free_idx] <= c_qty; s_id[free_idx] <= c_id;
      end
      if (cmd.emit_status) begin
        maker_id <= '0; fill_price <= '0; last <= 1'b1;
        if (c_cmd == CMD_BAD) begin
          kind <= K_MISS; taker_ref <= '0; amount <= '0;
        end else if (c_cmd == CMD_CANCEL) begin
          kind <= best_ok ? K_CANCELLED : K_MISS;
          taker_ref <= c_cid; amount <= '0;
        end else begin
          taker_ref <= c_id; amount <= c_qty;
          if (c_cmd == CMD_MARKET || c_qty == 32'd0) kind <= K_DONE;
          else if (free_ok) kind <= K_RESTED;
          else kind <= K_FULL;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(amount)) else $error("output lost");
  a_fill_used: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> used[best]) else $error("fill on free slot");
  a_fill_nz: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> f != 32'd0) else $error("zero fill");
`endif
endmodule
`default_nettype wire

@@ rtl/order_book_matcher_top.sv @@
// Top level: order book matcher, controller plus datapath.
//  channel | signals                                   | dir
//  in      | in_valid/in_stall, cmd side price ...      | in
//  out     | out_valid/out_stall, kind maker_id ... last | out
// One command in flight at a time; each scan walks all slots, one per cycle.
// Cancel stops its scan at the first matching slot.
// Reset empties the book and sets the next id to one, no clearing pass.
// Output stalls hold the controller; the result register holds one transaction.
`timescale 1ns / 1ps
`default_nettype none
module order_book_matcher_top
  import obm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic        side,
  input  wire logic [31:0] price,
  input  wire logic [31:0] quantity,
  input  wire logic [31:0] cancel_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [31:0]      maker_id,
  output logic [31:0]      taker_ref,
  output logic [31:0]      fill_price,
  output logic [31:0]      amount,
  output logic             last
);
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  obm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .stat(dstat), .cmd(dcmd)
  );

  obm_datapath u_dp (
    .clk, .rst, .cmd(dcmd), .stat(dstat),
    .in_cmd(cmd), .in_side(side), .in_price(price), .in_quantity(quantity),
    .in_cancel_id(cancel_id), .out_valid, .out_stall, .kind, .maker_id,
    .taker_ref, .fill_price, .amount, .last
  );
endmodule
`default_nettype wire
